// File: rtl/rapq_pkg.sv
// shared types and constants for the range add / predecessor query unit
package rapq_pkg;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_LOAD  = 2'd2;

    localparam int unsigned IDX_W = 10;
    localparam int unsigned LEN_W = 11;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0]        func;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  last_index;
        logic signed [31:0] operand;
    } in_word_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] best_value;
    } out_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the input word and set up the walk
        logic step;      // process one element
        logic finish;    // present the query result
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_query;
        logic walk;      // the word needs an element walk
        logic last;      // current element is the final one
    } stat_t;

endpackage

// File: rtl/rapq_datapath.sv
// element memory, walk address counter and predecessor search
module rapq_datapath #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rapq_pkg::in_word_t            in_word,
    input  logic [rapq_pkg::LEN_W-1:0]    length_in_use,
    input  rapq_pkg::cmd_t                cmd,
    output rapq_pkg::stat_t               stat,
    output rapq_pkg::out_word_t           result
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned NW = $clog2(DEPTH + 1);
    localparam int unsigned CW = (NW > rapq_pkg::LEN_W) ? NW : rapq_pkg::LEN_W;

    logic signed [31:0] mem [DEPTH];

    logic [1:0]        func_reg;
    logic signed [31:0] opnd_reg;
    logic [CW-1:0]     addr_reg, addr_next;
    logic [CW-1:0]     hi_reg;
    logic              found_reg, found_next;
    logic signed [31:0] best_reg, best_next;
    logic signed [31:0] rd_reg;

    // effective length and clipped range
    logic [CW-1:0] n_eff, lo_w, hi_w, hi_clip;
    logic          range_ok;
    always_comb
    begin
        n_eff = (CW'(length_in_use) > CW'(DEPTH)) ? CW'(DEPTH) : CW'(length_in_use);
        lo_w  = CW'(in_word.first_index);
        hi_w  = CW'(in_word.last_index);
        hi_clip = (n_eff != '0 && hi_w > n_eff - 1'b1) ? n_eff - 1'b1 : hi_w;
        range_ok = (n_eff != '0) && (lo_w < n_eff) && (lo_w <= hi_clip);
    end

    always_comb
    begin
        stat.is_query = (in_word.func == rapq_pkg::FUNC_QUERY);
        stat.walk = range_ok && (in_word.func == rapq_pkg::FUNC_ADD ||
                                 in_word.func == rapq_pkg::FUNC_QUERY);
        stat.last = (addr_reg == hi_reg);
    end

    // element memory: registered read of the next walk address, one write per cycle
    always_ff @(posedge clk)
    begin
        rd_reg <= mem[addr_next[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture && in_word.func == rapq_pkg::FUNC_LOAD && lo_w < n_eff)
        begin
            mem[lo_w[AW-1:0]] <= in_word.operand;
        end
        else if (cmd.step && func_reg == rapq_pkg::FUNC_ADD)
        begin
            mem[addr_reg[AW-1:0]] <= rd_reg + opnd_reg;
        end
    end

    // search accumulator and walk pointer
    always_comb
    begin
        addr_next  = addr_reg;
        found_next = found_reg;
        best_next  = best_reg;
        if (cmd.capture)
        begin
            addr_next  = lo_w;
            found_next = 1'b0;
            best_next  = '0;
        end
        else if (cmd.step)
        begin
            addr_next = addr_reg + 1'b1;
            if (rd_reg < opnd_reg && (!found_reg || best_reg < rd_reg))
            begin
                found_next = 1'b1;
                best_next  = rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        best_reg <= best_next;
        if (cmd.capture)
        begin
            func_reg <= in_word.func;
            opnd_reg <= in_word.operand;
            hi_reg   <= hi_clip;
        end
    end

    // result word, held until the next finish
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            result.found      <= found_reg;
            result.best_value <= found_reg ? best_reg : 32'sd0;
        end
    end
endmodule

// File: rtl/rapq_ctrl.sv
// controller: accept, walk, and output handshake
module rapq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              cfg_ready,
    input  rapq_pkg::stat_t   stat,
    output rapq_pkg::cmd_t    cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       query_reg, query_next;
    logic       ov_reg, ov_next;
    logic       accept;

    // a new word waits while a walk runs, a query result is being presented, or a result has not left
    assign in_stall  = (state_reg != ST_IDLE) || ov_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = ov_reg;
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;

    always_comb
    begin
        state_next = state_reg;
        query_next = query_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    query_next  = stat.is_query;
                    if (stat.walk)
                        state_next = ST_WALK;
                    else if (stat.is_query)
                        state_next = ST_DONE;
                end
            end
            ST_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.last)
                    state_next = query_reg ? ST_DONE : ST_IDLE;
            end
            default:
            begin
                cmd.finish = 1'b1;
                ov_next    = 1'b1;
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            query_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            query_reg <= query_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

// File: rtl/range_add_predecessor_query_unit.sv
// top level of the range add / range predecessor query unit
// One word is handled at a time. A load is written to memory as it is accepted. A
// range add over N elements runs the walk state after the capture, and a range query
// the walk and then the done state before its result is valid, one element read (and
// for an add, written back) per cycle through the element memory with a registered read;
// an empty range has N = 0 and skips the walk. A query result then waits in the output
// register until taken, and the next word is accepted the cycle after that. Length changes
// are accepted on the configuration channel only while the unit is idle and no word is offered.
module range_add_predecessor_query_unit #(
    parameter int unsigned DEPTH = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  rapq_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output rapq_pkg::out_word_t           out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rapq_pkg::LEN_W-1:0]    cfg_data
);
    logic [rapq_pkg::LEN_W-1:0] len_reg;
    rapq_pkg::cmd_t  cmd;
    rapq_pkg::stat_t stat;

    // length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            len_reg <= rapq_pkg::LEN_RESET;
        else if (cfg_valid && cfg_ready)
            len_reg <= cfg_data;
    end

    rapq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall),
        .cfg_ready(cfg_ready), .stat(stat), .cmd(cmd)
    );

    rapq_datapath #(.DEPTH(DEPTH)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_word),
        .length_in_use(len_reg), .cmd(cmd), .stat(stat), .result(out_word)
    );

    // a result never appears without a finish command the cycle before
    a_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish)) else $error("spurious result");
    // no new word accepted while a result is pending
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("word accepted over pending result");
    // commands are exclusive
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.step, cmd.finish})) else $error("command clash");
endmodule
